FILE: sv/lpl_pkg.sv
// Shared types, widths and constant helpers for the permutation lookup block.
`default_nettype none
package lpl_pkg;

   localparam int RANK_W        = 16;
   localparam int POS_W         = 3;
   localparam int SYM_W         = 4;
   localparam int CNT_W         = 4;
   localparam int SAT_W         = RANK_W + 1;
   localparam int MAX_POSITIONS = 1 << POS_W;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = 1;
   localparam int QCNT_W        = 2;

   localparam logic [SAT_W-1:0] SAT_LIMIT = SAT_W'(1) << RANK_W;

   // One classified query as it waits between the front and the back.
   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [POS_W-1:0]  pos;
      logic              err;
   } item_type;

   // k times j factorial, clipped just above the largest rank.
   function automatic logic [SAT_W-1:0] sat_mult(input int j, input int k);
      longint acc;
      acc = longint'(k);
      for (int i = 2; i <= j; i++) begin
         acc = acc * longint'(i);
         if (acc > longint'(SAT_LIMIT)) begin
            acc = longint'(SAT_LIMIT);
         end
      end
      if (acc > longint'(SAT_LIMIT)) begin
         acc = longint'(SAT_LIMIT);
      end
      return SAT_W'(acc);
   endfunction

endpackage
`default_nettype wire

FILE: sv/lpl_front.sv
// Front end: takes query beats and flags out-of-range ranks and positions.
`default_nettype none
module lpl_front import lpl_pkg::*; #(
   parameter int MAX_SYMBOLS = 8
) (
   input  wire logic              req_push,
   input  wire logic [RANK_W-1:0] req_perm_rank,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire logic [CNT_W-1:0]  eff_count,
   input  wire logic              queue_full,
   output logic                   req_full,
   output logic                   push_valid,
   output item_type               push_item
);

   logic [SAT_W-1:0] fact_tab [MAX_SYMBOLS+1];

   for (genvar c = 0; c <= MAX_SYMBOLS; c++) begin : g_fact
      assign fact_tab[c] = sat_mult(c, 1);
   end

   logic rank_bad;
   logic pos_bad;

   assign rank_bad = {1'b0, req_perm_rank} >= fact_tab[eff_count];
   assign pos_bad  = CNT_W'(req_position) >= eff_count;

   assign req_full       = queue_full;
   assign push_valid     = req_push && !queue_full;
   assign push_item.rank = req_perm_rank;
   assign push_item.pos  = req_position;
   assign push_item.err  = rank_bad || pos_bad;

endmodule
`default_nettype wire

FILE: sv/lpl_queue.sv
// Short register queue that decouples the front end from the unranking pipeline.
`default_nettype none
module lpl_queue import lpl_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  item_type      push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          empty,
   output item_type      head_item
);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: sv/lpl_back.sv
// Back end: one pipeline stage per factorial digit, each picking the digit-th unused symbol.
`default_nettype none
module lpl_back import lpl_pkg::*; #(
   parameter int MAX_SYMBOLS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CNT_W-1:0]  eff_count,
   input  wire logic              in_valid,
   input  item_type               in_item,
   output logic                   in_take,
   output logic                   out_valid,
   input  wire logic              out_pop,
   output logic [SYM_W-1:0]       symbol_value,
   output logic                   range_error
);

   localparam int DEPTH = (MAX_SYMBOLS < MAX_POSITIONS) ? MAX_SYMBOLS : MAX_POSITIONS;
   localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

   typedef struct packed {
      logic [RANK_W-1:0]      rank;
      logic [POS_W-1:0]       pos;
      logic                   err;
      logic [MAX_SYMBOLS-1:0] used;
      logic [SYM_W-1:0]       sym;
   } stage_type;

   logic [SAT_W-1:0] mult_tab [MAX_SYMBOLS][MAX_SYMBOLS];

   for (genvar j = 0; j < MAX_SYMBOLS; j++) begin : g_row
      for (genvar k = 0; k < MAX_SYMBOLS; k++) begin : g_col
         assign mult_tab[j][k] = sat_mult(j, k);
      end
   end

   stage_type stage_ff  [DEPTH];
   stage_type stage_in  [DEPTH];
   stage_type stage_src [DEPTH];
   logic      src_valid [DEPTH];
   logic      valid_ff  [DEPTH];
   logic      adv       [DEPTH+1];

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      adv[DEPTH] = out_pop;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign in_take = in_valid && adv[0];

   always_comb begin
      stage_src[0].rank = in_item.rank;
      stage_src[0].pos  = in_item.pos;
      stage_src[0].err  = in_item.err;
      stage_src[0].used = '0;
      stage_src[0].sym  = '0;
      src_valid[0]      = in_valid;
      for (int i = 1; i < DEPTH; i++) begin
         stage_src[i] = stage_ff[i-1];
         src_valid[i] = valid_ff[i-1];
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_stage
      logic [CNT_W-1:0] j_full;
      logic [IDX_W-1:0] j_idx;
      logic             active;

      assign j_full = eff_count - CNT_W'(i + 1);
      assign j_idx  = j_full[IDX_W-1:0];
      assign active = !stage_src[i].err && (POS_W'(i) <= stage_src[i].pos);

      always_comb begin
         logic [CNT_W-1:0]       digit;
         logic [IDX_W-1:0]       digit_idx;
         logic [MAX_SYMBOLS-1:0] free_mask;
         logic [MAX_SYMBOLS-1:0] hit;
         logic [SYM_W-1:0]       pick;
         logic [SAT_W-1:0]       base;
         digit = '0;
         for (int k = 1; k < MAX_SYMBOLS; k++) begin
            if ({1'b0, stage_src[i].rank} >= mult_tab[j_idx][k]) begin
               digit = digit + 1'b1;
            end
         end
         digit_idx = digit[IDX_W-1:0];
         base      = mult_tab[j_idx][digit_idx];
         free_mask = ~stage_src[i].used;
         hit       = '0;
         pick      = '0;
         // The digit-th free symbol: count free symbols below each candidate.
         for (int s = 0; s < MAX_SYMBOLS; s++) begin
            if (free_mask[s] &&
                CNT_W'($countones(free_mask & ((MAX_SYMBOLS'(1) << s) - 1'b1))) == digit) begin
               hit[s] = 1'b1;
               pick   = SYM_W'(s + 1);
            end
         end
         stage_in[i] = stage_src[i];
         if (active) begin
            stage_in[i].rank = stage_src[i].rank - base[RANK_W-1:0];
            stage_in[i].used = stage_src[i].used | hit;
            if (POS_W'(i) == stage_src[i].pos) begin
               stage_in[i].sym = pick;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= src_valid[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (adv[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign out_valid    = valid_ff[DEPTH-1];
   assign range_error  = stage_ff[DEPTH-1].err;
   assign symbol_value = stage_ff[DEPTH-1].err ? '0 : stage_ff[DEPTH-1].sym;

endmodule
`default_nettype wire

FILE: sv/lexicographic_permutation_lookup.sv
// Top level of the lexicographic permutation lookup: register, front end, queue, unranker.
`default_nettype none
// Each request beat carries a permutation rank and a position; the response beat gives the
// symbol (1..count) at that position of the rank-th lexicographic permutation of 1..count,
// or zero with range_error set when the rank is at least count factorial or the position is
// at least count. The count comes from the one configuration register (reset value 8; a
// write of 0 acts as 1 and anything above MAX_SYMBOLS acts as MAX_SYMBOLS) and may only be
// written while no beats are in flight. A new request beat is taken every cycle while
// req_full is low. An accepted request beat waits in the two-entry queue behind the range
// check, then passes one pipeline stage per factorial digit, where each stage compares
// the rank against the multiples of one factorial and picks the unused symbol that its
// digit selects. The last stage is the response register, so a waiting response does
// not block new requests until the pipeline and queue are full; responses leave in
// request order.
module lexicographic_permutation_lookup import lpl_pkg::*; #(
   parameter int MAX_SYMBOLS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [RANK_W-1:0] req_perm_rank,
   input  wire logic [POS_W-1:0]  req_position,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [SYM_W-1:0]       rsp_symbol_value,
   output logic                   rsp_range_error,
   input  wire logic              csr_write_enable,
   input  wire logic [CNT_W-1:0]  csr_write_data
);

   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(8);
   localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_SYMBOLS);

   logic [CNT_W-1:0] symbol_count_ff;
   logic [CNT_W-1:0] eff_count;

   // The register keeps what was written; the clamped count feeds the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         symbol_count_ff <= csr_write_data;
      end
   end

   always_comb begin
      priority if (symbol_count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (symbol_count_ff > COUNT_MAX) begin
         eff_count = COUNT_MAX;
      end else begin
         eff_count = symbol_count_ff;
      end
   end

   logic     queue_full;
   logic     push_valid;
   item_type push_item;
   logic     queue_empty;
   item_type head_item;
   logic     back_take;
   logic     back_valid;

   lpl_front #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_front (
      .req_push      (req_push),
      .req_perm_rank (req_perm_rank),
      .req_position  (req_position),
      .eff_count     (eff_count),
      .queue_full    (queue_full),
      .req_full      (req_full),
      .push_valid    (push_valid),
      .push_item     (push_item)
   );

   lpl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (back_take),
      .empty     (queue_empty),
      .head_item (head_item)
   );

   lpl_back #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .eff_count    (eff_count),
      .in_valid     (!queue_empty),
      .in_item      (head_item),
      .in_take      (back_take),
      .out_valid    (back_valid),
      .out_pop      (rsp_pop),
      .symbol_value (rsp_symbol_value),
      .range_error  (rsp_range_error)
   );

   assign rsp_empty = !back_valid;

endmodule
`default_nettype wire
